>>> src/hpps_pkg.sv
// Shared types, codes and constants for the haptic pulse pattern sequencer.
package hpps_pkg;

    localparam int unsigned DUTY_W  = 10;
    localparam int unsigned RAMP_W  = 10;
    localparam int unsigned HOLD_W  = 12;
    localparam int unsigned TOUT_W  = 16;
    localparam int unsigned SEG_W   = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Request codes carried in s_tuser
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_LEVEL = 2'd1;
    localparam logic [1:0] REQ_OFF   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd5;

    // Segment codes
    localparam logic [SEG_W-1:0] SEG_LAST_SINGLE = 4'd5;
    localparam logic [SEG_W-1:0] SEG_GAP         = 4'd6;
    localparam logic [SEG_W-1:0] SEG_SECOND      = 4'd7;
    localparam logic [SEG_W-1:0] SEG_LAST_DOUBLE = 4'd12;

    // Positions within one pulse
    localparam logic [SEG_W-1:0] POS_RISE_LO     = 4'd0;
    localparam logic [SEG_W-1:0] POS_RISE_MID    = 4'd1;
    localparam logic [SEG_W-1:0] POS_HOLD        = 4'd3;
    localparam logic [SEG_W-1:0] POS_FALL_MID    = 4'd4;
    localparam logic [SEG_W-1:0] POS_FALL_LO     = 4'd5;

    localparam logic [1:0] RANK_DOUBLE = 2'd2;
    localparam logic [1:0] RANK_LONG   = 2'd3;

    localparam logic [DUTY_W-1:0] DUTY_LIMIT = 10'd1000;
    localparam logic [TOUT_W-1:0] ELAPSED_MAX = 16'hFFFF;

    // floor(m*0.33) and floor(m*0.66) as m*C >> 20, exact for m <= 1000
    localparam int unsigned LVL_SHIFT = 20;
    localparam logic [19:0] LVL33_MUL = 20'd346031;
    localparam logic [19:0] LVL66_MUL = 20'd692061;

    // Reset values
    localparam logic [DUTY_W-1:0] RST_FULL  = 10'd800;
    localparam logic [DUTY_W-1:0] RST_L33   = 10'd264;
    localparam logic [DUTY_W-1:0] RST_L66   = 10'd528;
    localparam logic [RAMP_W-1:0] RST_RAMP  = 10'd30;
    localparam logic [HOLD_W-1:0] RST_SHORT = 12'd180;
    localparam logic [HOLD_W-1:0] RST_LONG  = 12'd450;
    localparam logic [HOLD_W-1:0] RST_GAP   = 12'd100;
    localparam logic [TOUT_W-1:0] RST_TOUT  = 16'd1000;

    typedef struct packed {
        logic [DUTY_W-1:0] full;
        logic [DUTY_W-1:0] l33;
        logic [DUTY_W-1:0] l66;
        logic [RAMP_W-1:0] ramp;
        logic [HOLD_W-1:0] short_hold;
        logic [HOLD_W-1:0] long_hold;
        logic [HOLD_W-1:0] gap;
        logic [TOUT_W-1:0] timeout;
    } cfg_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              active;
        logic              notice;
    } result_t;

endpackage

>>> src/hpps_cfg.sv
// Configuration registers with duty levels precomputed at write time.
module hpps_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wen,
    input  logic [hpps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hpps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output hpps_pkg::cfg_t                    cfg
);

    hpps_pkg::cfg_t cfg_reg;
    logic [hpps_pkg::DUTY_W-1:0] wr_duty;
    logic [hpps_pkg::DUTY_W-1:0] wr_full;
    logic [29:0] prod33;
    logic [29:0] prod66;

    assign wr_duty = cfg_wdata[hpps_pkg::DUTY_W-1:0];
    assign wr_full = (wr_duty > hpps_pkg::DUTY_LIMIT) ? hpps_pkg::DUTY_LIMIT : wr_duty;
    assign prod33  = 30'(wr_full) * 30'(hpps_pkg::LVL33_MUL);
    assign prod66  = 30'(wr_full) * 30'(hpps_pkg::LVL66_MUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.full       <= hpps_pkg::RST_FULL;
            cfg_reg.l33        <= hpps_pkg::RST_L33;
            cfg_reg.l66        <= hpps_pkg::RST_L66;
            cfg_reg.ramp       <= hpps_pkg::RST_RAMP;
            cfg_reg.short_hold <= hpps_pkg::RST_SHORT;
            cfg_reg.long_hold  <= hpps_pkg::RST_LONG;
            cfg_reg.gap        <= hpps_pkg::RST_GAP;
            cfg_reg.timeout    <= hpps_pkg::RST_TOUT;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                hpps_pkg::CFG_MAX_DUTY: begin
                    cfg_reg.full <= wr_full;
                    cfg_reg.l33  <= prod33[hpps_pkg::LVL_SHIFT +: hpps_pkg::DUTY_W];
                    cfg_reg.l66  <= prod66[hpps_pkg::LVL_SHIFT +: hpps_pkg::DUTY_W];
                end
                hpps_pkg::CFG_RAMP:    cfg_reg.ramp       <= cfg_wdata[hpps_pkg::RAMP_W-1:0];
                hpps_pkg::CFG_SHORT:   cfg_reg.short_hold <= cfg_wdata[hpps_pkg::HOLD_W-1:0];
                hpps_pkg::CFG_LONG:    cfg_reg.long_hold  <= cfg_wdata[hpps_pkg::HOLD_W-1:0];
                hpps_pkg::CFG_GAP:     cfg_reg.gap        <= cfg_wdata[hpps_pkg::HOLD_W-1:0];
                hpps_pkg::CFG_TIMEOUT: cfg_reg.timeout    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/hpps_core.sv
// Pattern state registers and the single-pass next-state and result logic.
module hpps_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [1:0]        req_type,
    input  logic [1:0]        level_rank,
    input  hpps_pkg::cfg_t    cfg,
    output hpps_pkg::result_t result
);

    logic                          busy_reg, busy_next;
    logic [1:0]                    pending_reg, pending_next;
    logic [1:0]                    playing_reg, playing_next;
    logic [hpps_pkg::SEG_W-1:0]    seg_reg, seg_next;
    logic [hpps_pkg::HOLD_W-1:0]   ticks_reg, ticks_next;
    logic [hpps_pkg::TOUT_W-1:0]   elapsed_reg, elapsed_next;
    logic [hpps_pkg::DUTY_W-1:0]   duty_reg, duty_next;
    logic                          notice;

    logic [hpps_pkg::TOUT_W-1:0]   elapsed_inc;
    logic [hpps_pkg::HOLD_W-1:0]   ticks_inc;
    logic [hpps_pkg::SEG_W-1:0]    pos_cur, seg_adv, pos_adv;
    logic [hpps_pkg::HOLD_W-1:0]   dur_raw, seg_len;
    logic [hpps_pkg::SEG_W-1:0]    seg_last;
    logic [hpps_pkg::DUTY_W-1:0]   adv_duty;

    assign elapsed_inc = (elapsed_reg == hpps_pkg::ELAPSED_MAX) ? elapsed_reg
                                                              : elapsed_reg + 1'b1;
    assign ticks_inc   = ticks_reg + 1'b1;
    assign pos_cur     = (seg_reg > hpps_pkg::SEG_GAP) ? seg_reg - hpps_pkg::SEG_SECOND
                                                       : seg_reg;
    assign seg_adv     = seg_reg + 1'b1;
    assign pos_adv     = (seg_adv > hpps_pkg::SEG_GAP) ? seg_adv - hpps_pkg::SEG_SECOND
                                                       : seg_adv;
    assign seg_last    = (playing_reg == hpps_pkg::RANK_DOUBLE) ? hpps_pkg::SEG_LAST_DOUBLE
                                                                : hpps_pkg::SEG_LAST_SINGLE;

    always_comb begin
        priority if (seg_reg == hpps_pkg::SEG_GAP) begin
            dur_raw = cfg.gap;
        end else if (pos_cur == hpps_pkg::POS_HOLD) begin
            dur_raw = (playing_reg == hpps_pkg::RANK_LONG) ? cfg.long_hold : cfg.short_hold;
        end else begin
            dur_raw = hpps_pkg::HOLD_W'(cfg.ramp);
        end
        seg_len = (dur_raw == '0) ? hpps_pkg::HOLD_W'(1) : dur_raw;
    end

    always_comb begin
        priority if (seg_adv == hpps_pkg::SEG_GAP) begin
            adv_duty = '0;
        end else if (pos_adv == hpps_pkg::POS_RISE_LO || pos_adv == hpps_pkg::POS_FALL_LO) begin
            adv_duty = cfg.l33;
        end else if (pos_adv == hpps_pkg::POS_RISE_MID
                     || pos_adv == hpps_pkg::POS_FALL_MID) begin
            adv_duty = cfg.l66;
        end else begin
            adv_duty = cfg.full;
        end
    end

    always_comb begin
        busy_next    = busy_reg;
        pending_next = pending_reg;
        playing_next = playing_reg;
        seg_next     = seg_reg;
        ticks_next   = ticks_reg;
        elapsed_next = elapsed_reg;
        duty_next    = duty_reg;
        notice       = 1'b0;
        unique case (req_type)
            hpps_pkg::REQ_TICK: begin
                if (busy_reg) begin
                    if (elapsed_inc > cfg.timeout) begin
                        // drop the pattern on timeout
                        busy_next    = 1'b0;
                        playing_next = '0;
                        seg_next     = '0;
                        ticks_next   = '0;
                        elapsed_next = '0;
                        duty_next    = '0;
                        notice       = 1'b1;
                    end else if (ticks_inc >= seg_len) begin
                        elapsed_next = elapsed_inc;
                        ticks_next   = '0;
                        if (seg_reg >= seg_last) begin
                            busy_next    = 1'b0;
                            playing_next = '0;
                            seg_next     = '0;
                            elapsed_next = '0;
                            duty_next    = '0;
                            notice       = 1'b1;
                        end else begin
                            seg_next  = seg_adv;
                            duty_next = adv_duty;
                        end
                    end else begin
                        elapsed_next = elapsed_inc;
                        ticks_next   = ticks_inc;
                    end
                end
            end
            hpps_pkg::REQ_LEVEL: begin
                if (level_rank != 2'd0) begin
                    if (busy_reg) begin
                        if (level_rank > pending_reg) pending_next = level_rank;
                    end else begin
                        busy_next    = 1'b1;
                        elapsed_next = '0;
                        playing_next = (level_rank > pending_reg) ? level_rank : pending_reg;
                        pending_next = '0;
                        seg_next     = '0;
                        ticks_next   = '0;
                        duty_next    = cfg.l33;
                    end
                end
            end
            hpps_pkg::REQ_OFF: begin
                busy_next    = 1'b0;
                playing_next = '0;
                seg_next     = '0;
                ticks_next   = '0;
                elapsed_next = '0;
                duty_next    = '0;
                notice       = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pending_reg <= '0;
            playing_reg <= '0;
            seg_reg     <= '0;
            ticks_reg   <= '0;
            elapsed_reg <= '0;
            duty_reg    <= '0;
        end else if (step) begin
            busy_reg    <= busy_next;
            pending_reg <= pending_next;
            playing_reg <= playing_next;
            seg_reg     <= seg_next;
            ticks_reg   <= ticks_next;
            elapsed_reg <= elapsed_next;
            duty_reg    <= duty_next;
        end
    end

    assign result.duty   = duty_next;
    assign result.active = busy_next;
    assign result.notice = notice;

endmodule

>>> src/haptic_pulse_pattern_sequencer.sv
// Top level of the haptic pulse pattern sequencer: stream ports and result register.
// A request's result appears on m_tdata in the cycle after it is accepted.
// One request is taken per cycle; s_tready drops only while a result waits unread.
// Each request updates the pattern state and builds its result in a single combinational pass.
// Reset (aresetn low, synchronous) clears the pattern state, empties the result
// register and loads the default register values.
module haptic_pulse_pattern_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // [1:0] level_rank
    input  logic [1:0]                        s_tuser,  // [1:0] req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,  // [9:0] duty_permille, [10] active,
                                                        // [11] reset_notice
    input  logic                              cfg_wen,
    input  logic [hpps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hpps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    hpps_pkg::cfg_t    cfg;
    hpps_pkg::result_t result;
    hpps_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              s_fire;
    logic [5:0]        unused_tdata;

    assign s_tready     = !out_valid_reg || m_tready;
    assign s_fire       = s_tvalid && s_tready;
    assign unused_tdata = s_tdata[7:2];

    hpps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hpps_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (s_fire),
        .req_type   (s_tuser),
        .level_rank (s_tdata[1:0]),
        .cfg        (cfg),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.notice, out_reg.active, out_reg.duty};

endmodule

>>> src/hpps_checker.sv
// Port-level checks of the sequencer's result stream, bound to the top level.
module hpps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_notice_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[11] |-> !m_tdata[10] && m_tdata[9:0] == 10'd0)
        else $error("reset notice with output still driven");

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[10] |-> m_tdata[9:0] == 10'd0)
        else $error("duty nonzero while idle");

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[9:0] <= 10'd1000 && m_tdata[15:12] == 4'd0)
        else $error("duty out of range");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind haptic_pulse_pattern_sequencer hpps_checker u_hpps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
